FILE: sv/tcr_pkg.sv
// ----------------------------------------------------------------------------
// Textured column renderer package
// Shared constants, register indexes, region codes and controller states.
// ----------------------------------------------------------------------------
package tcr_pkg;

  localparam int unsigned DEF_NUM_TEXTURES    = 4;
  localparam int unsigned DEF_MAX_TEXTURE_DIM = 64;

  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned DEN_W      = 12;
  localparam int unsigned DEF_DIV_NUM_W = $clog2(DEF_MAX_TEXTURE_DIM + 1) + FRAC_W;
  localparam int unsigned BPP_SHIFT  = $clog2(32 / 8);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned REGION_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXTURE_WIDTH  = 3'd0,
    CFG_TEXTURE_HEIGHT = 3'd1,
    CFG_SCREEN_WIDTH   = 3'd2,
    CFG_SCREEN_HEIGHT  = 3'd3,
    CFG_FILL_ABOVE     = 3'd4,
    CFG_FILL_BELOW     = 3'd5
  } tcr_cfg_e;

  typedef enum logic [REGION_W-1:0] {
    REGION_ABOVE = 2'd0,
    REGION_WALL  = 2'd1,
    REGION_BELOW = 2'd2
  } tcr_region_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_POS,
    ST_MOD,
    ST_ADDR,
    ST_DATA
  } tcr_state_e;

endpackage

FILE: sv/textured_column_renderer.sv
// ----------------------------------------------------------------------------
// Textured column renderer
// Draws one raycaster screen column a pixel at a time from a texel memory,
// with fill colors above and below the wall.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                Word
//   input     in         in_valid_i / in_ready_o  load texel or draw one row
//   output    out        out_valid_o / out_ready_i byte address, 3 bytes, region
//   config    in         cfg_we_i                 register index and data
//
// The first row of a wall also runs the step division; a texel row found at
// or past the texture height runs the divider again to wrap it into range.
// Reset clears control state and the configuration registers; the texel
// memory is not cleared.
// A new word is taken while a finished result waits in the output register.
module textured_column_renderer #(
  parameter int unsigned NUM_TEXTURES    = tcr_pkg::DEF_NUM_TEXTURES,
  parameter int unsigned MAX_TEXTURE_DIM = tcr_pkg::DEF_MAX_TEXTURE_DIM
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [10:0]                    column_x_i,
  input  logic [10:0]                    row_y_i,
  input  logic [11:0]                    wall_start_i,
  input  logic [11:0]                    wall_end_i,
  input  logic [5:0]                     texture_column_i,
  input  logic [1:0]                     texture_select_i,
  input  logic [13:0]                    texel_index_i,
  input  logic [23:0]                    texel_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [23:0]                    byte_address_o,
  output logic [7:0]                     byte_0_o,
  output logic [7:0]                     byte_1_o,
  output logic [7:0]                     byte_2_o,
  output logic [tcr_pkg::REGION_W-1:0]   region_o
);

  import tcr_pkg::*;

  localparam int unsigned DIM_W       = $clog2(MAX_TEXTURE_DIM + 1);
  localparam int unsigned ROW_W       = $clog2(MAX_TEXTURE_DIM);
  localparam int unsigned TEX_AREA    = MAX_TEXTURE_DIM * MAX_TEXTURE_DIM;
  localparam int unsigned STORE_DEPTH = NUM_TEXTURES * TEX_AREA;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned NUM_W       = DIM_W + FRAC_W;
  localparam int unsigned PROD_W      = ROW_W + DIM_W;
  localparam int unsigned SUM_W       = PROD_W + 1;
  localparam int unsigned INT_W       = POS_W - FRAC_W;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [6:0] v);
    logic [DIM_W-1:0] r;
    if (v == 7'd0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_TEXTURE_DIM) begin
      r = DIM_W'(MAX_TEXTURE_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  function automatic logic [1:0] tsel_wrap(input logic [1:0] v);
    logic [1:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (32'(r) >= NUM_TEXTURES) begin
        r = r - 2'(NUM_TEXTURES);
      end
    end
    return r;
  endfunction

  // Configuration registers.
  logic [6:0]         tw_cfg_q;
  logic [6:0]         th_cfg_q;
  logic [11:0]        sw_q;
  logic [11:0]        sh_q;
  logic [COLOR_W-1:0] fill_above_q;
  logic [COLOR_W-1:0] fill_below_q;

  // Captured word.
  logic        cmd_q;
  logic [10:0] x_q;
  logic [10:0] y_q;
  logic [11:0] ws_q;
  logic [11:0] we_q;
  logic [5:0]  tcol_q;
  logic [1:0]  tsel_q;
  logic [13:0] tidx_q;
  logic [23:0] tval_q;

  tcr_state_e state_q, state_d;

  logic [POS_W-1:0] step_q;
  logic [POS_W-1:0] pos_q;
  logic [ROW_W-1:0] trow_q;

  logic [23:0] texel_mem_q [STORE_DEPTH];
  logic [23:0] rdata_q;

  logic          out_valid_q;
  logic [23:0]   out_addr_q;
  logic [7:0]    out_b0_q;
  logic [7:0]    out_b1_q;
  logic [7:0]    out_b2_q;
  tcr_region_e   region_q;

  // Control from the output decoder.
  logic             accept;
  logic             mem_we;
  logic             mem_re;
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             step_load;
  logic             pos_adv;
  logic             trow_from_pos;
  logic             trow_from_rem;
  logic             out_load;
  tcr_region_e      out_region;

  logic             div_done;
  logic [NUM_W-1:0] div_quot;
  logic [DEN_W-1:0] div_rem;

  // Datapath.
  logic [DIM_W-1:0]  tw;
  logic [DIM_W-1:0]  th;
  logic              on_screen;
  logic              above;
  logic              in_wall;
  logic              first_row;
  logic              load_ok;
  logic              out_free;
  logic [11:0]       wall_len;
  logic [INT_W-1:0]  int_part;
  logic              in_range;
  logic [22:0]       y_prod;
  logic [23:0]       lin_addr;
  logic [23:0]       byte_addr;
  logic [PROD_W-1:0] tex_prod;
  logic [SUM_W-1:0]  tex_sum;
  logic [SUM_W-1:0]  tex_inner;
  logic [31:0]       tex_full;
  logic [ADDR_W-1:0] rd_addr;
  logic [COLOR_W-1:0] fill_color;

  assign tw        = clamp_dim(tw_cfg_q);
  assign th        = clamp_dim(th_cfg_q);
  assign on_screen = ({1'b0, x_q} < sw_q) && ({1'b0, y_q} < sh_q);
  assign above     = {1'b0, y_q} < ws_q;
  assign in_wall   = !above && ({1'b0, y_q} < we_q);
  assign first_row = {1'b0, y_q} == ws_q;
  assign load_ok   = 32'(tidx_q) < STORE_DEPTH;
  assign out_free  = !out_valid_q || out_ready_i;
  assign wall_len  = we_q - ws_q;
  assign int_part  = pos_q[POS_W-1:FRAC_W];
  assign in_range  = int_part < INT_W'(th);

  assign y_prod    = y_q * sw_q;
  assign lin_addr  = 24'(y_prod) + 24'(x_q);
  assign byte_addr = lin_addr << BPP_SHIFT;

  assign tex_prod  = trow_q * tw;
  assign tex_sum   = SUM_W'(tex_prod) + SUM_W'(tcol_q);
  assign tex_inner = (32'(tex_sum) >= TEX_AREA) ? (tex_sum - SUM_W'(TEX_AREA)) : tex_sum;
  assign tex_full  = 32'(tsel_wrap(tsel_q)) * TEX_AREA + 32'(tex_inner);
  assign rd_addr   = ADDR_W'(tex_full);

  assign fill_color = above ? fill_above_q : fill_below_q;

  tcr_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!cmd_q || !on_screen) begin
          state_d = ST_IDLE;
        end else if (in_wall) begin
          state_d = first_row ? ST_DIV : ST_POS;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        state_d = in_range ? ST_ADDR : ST_MOD;
      end
      ST_MOD: begin
        if (div_done) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        state_d = ST_DATA;
      end
      ST_DATA: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    div_start     = 1'b0;
    div_num       = {th, FRAC_W'(0)};
    div_den       = wall_len;
    step_load     = 1'b0;
    pos_adv       = 1'b0;
    trow_from_pos = 1'b0;
    trow_from_rem = 1'b0;
    out_load      = 1'b0;
    out_region    = above ? REGION_ABOVE : REGION_BELOW;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_DECODE: begin
        if (!cmd_q) begin
          mem_we = load_ok;
        end else if (on_screen) begin
          if (in_wall) begin
            div_start = first_row;
          end else begin
            out_load = out_free;
          end
        end
      end
      ST_DIV: begin
        step_load = div_done;
      end
      ST_POS: begin
        pos_adv = 1'b1;
        if (in_range) begin
          trow_from_pos = 1'b1;
        end else begin
          div_start = 1'b1;
          div_num   = NUM_W'(int_part);
          div_den   = DEN_W'(th);
        end
      end
      ST_MOD: begin
        trow_from_rem = div_done;
      end
      ST_ADDR: begin
        mem_re = 1'b1;
      end
      ST_DATA: begin
        out_load   = out_free;
        out_region = REGION_WALL;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tw_cfg_q     <= 7'd64;
      th_cfg_q     <= 7'd64;
      sw_q         <= 12'd640;
      sh_q         <= 12'd480;
      fill_above_q <= '0;
      fill_below_q <= '0;
      step_q       <= '0;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TEXTURE_WIDTH:  tw_cfg_q     <= cfg_data_i[6:0];
          CFG_TEXTURE_HEIGHT: th_cfg_q     <= cfg_data_i[6:0];
          CFG_SCREEN_WIDTH:   sw_q         <= cfg_data_i[11:0];
          CFG_SCREEN_HEIGHT:  sh_q         <= cfg_data_i[11:0];
          CFG_FILL_ABOVE:     fill_above_q <= cfg_data_i[COLOR_W-1:0];
          CFG_FILL_BELOW:     fill_below_q <= cfg_data_i[COLOR_W-1:0];
          default: begin
          end
        endcase
      end
      if (step_load) begin
        step_q <= POS_W'(div_quot);
        pos_q  <= '0;
      end else if (pos_adv) begin
        pos_q <= pos_q + step_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      x_q    <= column_x_i;
      y_q    <= row_y_i;
      ws_q   <= wall_start_i;
      we_q   <= wall_end_i;
      tcol_q <= texture_column_i;
      tsel_q <= texture_select_i;
      tidx_q <= texel_index_i;
      tval_q <= texel_value_i;
    end
    if (trow_from_pos) begin
      trow_q <= ROW_W'(int_part);
    end else if (trow_from_rem) begin
      trow_q <= ROW_W'(div_rem);
    end
    if (out_load) begin
      out_addr_q <= byte_addr;
      region_q   <= out_region;
      if (out_region == REGION_WALL) begin
        out_b0_q <= rdata_q[7:0];
        out_b1_q <= rdata_q[15:8];
        out_b2_q <= rdata_q[23:16];
      end else begin
        out_b0_q <= fill_color[23:16];
        out_b1_q <= fill_color[15:8];
        out_b2_q <= fill_color[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      texel_mem_q[ADDR_W'(tidx_q)] <= tval_q;
    end
    if (mem_re) begin
      rdata_q <= texel_mem_q[rd_addr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_address_o = out_addr_q;
  assign byte_0_o       = out_b0_q;
  assign byte_1_o       = out_b1_q;
  assign byte_2_o       = out_b2_q;
  assign region_o       = region_q;

  a_wall_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DATA && out_free) |=> (out_valid_o && region_o == REGION_WALL))
    else $error("wall word was not loaded into the output register");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV || state_q == ST_MOD))
    else $error("divider finished outside a division state");

  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_done) |=> (pos_q == '0))
    else $error("texture position not cleared at the first wall row");

  a_trow_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADDR) |-> (DIM_W'(trow_q) < th))
    else $error("texel row at or past the texture height");

endmodule

FILE: sv/tcr_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider that produces one quotient bit per cycle and
// pulses done when quotient and remainder are ready.
// ----------------------------------------------------------------------------
module tcr_div #(
  parameter int unsigned NUM_W = tcr_pkg::DEF_DIV_NUM_W,
  parameter int unsigned DEN_W = tcr_pkg::DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign shifted = {rem_q, quot_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quot_d = {quot_q[NUM_W-2:0], ge};
      rem_d  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

FILE: bench/tb_textured_column_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Textured column renderer testbench
// Texel loads and column draws go in through a random-stall driver; every
// accepted word updates a behavioral renderer that queues the expected pixel,
// and a random-stall monitor checks each pixel against it, field by field.
// Texels are always loaded before any wall row can read them.
// ----------------------------------------------------------------------------
module tb_textured_column_renderer;
  import tcr_pkg::*;

  localparam int unsigned TEX_DIM         = DEF_MAX_TEXTURE_DIM;
  localparam int unsigned TEX_AREA        = TEX_DIM * TEX_DIM;
  localparam int unsigned STORE_DEPTH     = DEF_NUM_TEXTURES * TEX_AREA;
  localparam int unsigned BYTES_PER_PIXEL = 32 / 8;
  localparam int unsigned MAX_ROW         = 2047;
  localparam int unsigned MAX_WALL_ROW    = 2048;
  localparam int          IDLE_PCT        = 37;
  localparam int          QUIET_FROM      = 3000;
  localparam int          QUIET_TO        = 9000;
  localparam int          DRAIN_CYCLES    = 128;
  localparam int          LIMIT_CYCLES    = 1000000;
  localparam int          NUM_PHASES      = 8;
  localparam int          REPORT_MAX      = 10;
  localparam logic        CMD_LOAD        = 1'b0;
  localparam logic        CMD_DRAW        = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct packed {
    logic        cmd;
    logic [10:0] x;
    logic [10:0] y;
    logic [11:0] ws;
    logic [11:0] we;
    logic [5:0]  tcol;
    logic [1:0]  tsel;
    logic [13:0] tidx;
    logic [23:0] tval;
    logic        drain_first;
  } word_t;

  typedef struct packed {
    logic [23:0] addr;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    tcr_region_e region;
  } pixel_t;

  typedef struct packed {
    logic [31:0] step;
    logic [31:0] pos;
  } accum_t;

  typedef struct packed {
    accum_t      acc;
    logic [13:0] addr;
  } wall_tap_t;

  typedef struct packed {
    logic [6:0]  tex_w;
    logic [6:0]  tex_h;
    logic [11:0] scr_w;
    logic [11:0] scr_h;
    logic [23:0] above;
    logic [23:0] below;
  } raster_cfg_t;

  logic                  clk_i;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready_o;
  logic                  cmd        = 1'b0;
  logic [10:0]           column_x   = '0;
  logic [10:0]           row_y      = '0;
  logic [11:0]           wall_start = '0;
  logic [11:0]           wall_end   = '0;
  logic [5:0]            tex_column = '0;
  logic [1:0]            tex_select = '0;
  logic [13:0]           texel_idx  = '0;
  logic [23:0]           texel_val  = '0;
  logic                  out_valid_o;
  logic                  out_ready  = 1'b0;
  logic [23:0]           byte_address_o;
  logic [7:0]            byte_0_o;
  logic [7:0]            byte_1_o;
  logic [7:0]            byte_2_o;
  logic [REGION_W-1:0]   region_o;

  raster_cfg_t raster_cfg = '{tex_w: 7'd64, tex_h: 7'd64, scr_w: 12'd640,
                              scr_h: 12'd480, above: 24'h0, below: 24'h0};
  accum_t      plan_acc = '0;
  accum_t      live_acc = '0;
  logic [23:0] texel_mem [STORE_DEPTH];
  bit          loaded [STORE_DEPTH];
  word_t       pending_words [$];
  pixel_t      expected_pixels [$];
  word_t       cur_word;
  pixel_t      oldest_pixel;
  int          mismatches = 0;
  int          cycle = 0;

  textured_column_renderer u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd),
    .column_x_i       (column_x),
    .row_y_i          (row_y),
    .wall_start_i     (wall_start),
    .wall_end_i       (wall_end),
    .texture_column_i (tex_column),
    .texture_select_i (tex_select),
    .texel_index_i    (texel_idx),
    .texel_value_i    (texel_val),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .byte_address_o   (byte_address_o),
    .byte_0_o         (byte_0_o),
    .byte_1_o         (byte_1_o),
    .byte_2_o         (byte_2_o),
    .region_o         (region_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
  end

  function automatic int idle_pct();
    return (cycle >= QUIET_FROM && cycle < QUIET_TO) ? 0 : IDLE_PCT;
  endfunction

  function automatic int unsigned tex_dim(logic [6:0] v);
    if (v == 7'd0) begin
      return 1;
    end
    if (32'(v) > TEX_DIM) begin
      return TEX_DIM;
    end
    return 32'(v);
  endfunction

  function automatic bit on_screen(word_t w);
    return 32'(w.x) < 32'(raster_cfg.scr_w) && 32'(w.y) < 32'(raster_cfg.scr_h);
  endfunction

  function automatic tcr_region_e row_region(word_t w);
    if (32'(w.y) < 32'(w.ws)) begin
      return REGION_ABOVE;
    end
    if (32'(w.y) < 32'(w.we)) begin
      return REGION_WALL;
    end
    return REGION_BELOW;
  endfunction

  // The accumulator restarts only on the first wall row; otherwise it
  // carries on from wherever the previous wall row left it.
  function automatic wall_tap_t wall_tap(accum_t acc, word_t w);
    int unsigned th, tw, trow, offs;
    wall_tap_t   tap;
    th = tex_dim(raster_cfg.tex_h);
    tw = tex_dim(raster_cfg.tex_w);
    if (w.y == w.ws[10:0] && w.ws <= 12'(MAX_ROW)) begin
      acc.step = (th << FRAC_W) / (32'(w.we) - 32'(w.ws));
      acc.pos  = '0;
    end
    trow     = (acc.pos >> FRAC_W) % th;
    acc.pos  = acc.pos + acc.step;
    offs     = (trow * tw + 32'(w.tcol)) % TEX_AREA;
    tap.addr = 14'(offs + (32'(w.tsel) % DEF_NUM_TEXTURES) * TEX_AREA);
    tap.acc  = acc;
    return tap;
  endfunction

  task automatic shade_pixel(input word_t w);
    pixel_t      px;
    wall_tap_t   tap;
    logic [23:0] texel;
    logic [31:0] lin;
    if (w.cmd == CMD_LOAD) begin
      texel_mem[w.tidx] = w.tval;
    end else if (on_screen(w)) begin
      lin       = (32'(w.x) + 32'(w.y) * 32'(raster_cfg.scr_w)) * BYTES_PER_PIXEL;
      px.addr   = lin[23:0];
      px.region = row_region(w);
      case (px.region)
        REGION_ABOVE: begin
          {px.b0, px.b1, px.b2} = raster_cfg.above;
        end
        REGION_WALL: begin
          tap      = wall_tap(live_acc, w);
          live_acc = tap.acc;
          texel    = texel_mem[tap.addr];
          {px.b2, px.b1, px.b0} = texel;
        end
        default: begin
          {px.b0, px.b1, px.b2} = raster_cfg.below;
        end
      endcase
      expected_pixels.push_back(px);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        shade_pixel(cur_word);
      end
      if (!in_valid || in_ready_o) begin
        if (pending_words.size() != 0 &&
            !(pending_words[0].drain_first && expected_pixels.size() != 0) &&
            $urandom_range(0, 99) >= idle_pct()) begin
          cur_word   = pending_words.pop_front();
          in_valid   <= 1'b1;
          cmd        <= cur_word.cmd;
          column_x   <= cur_word.x;
          row_y      <= cur_word.y;
          wall_start <= cur_word.ws;
          wall_end   <= cur_word.we;
          tex_column <= cur_word.tcol;
          tex_select <= cur_word.tsel;
          texel_idx  <= cur_word.tidx;
          texel_val  <= cur_word.tval;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("unexpected pixel: addr %h bytes %h %h %h region %0d",
                     byte_address_o, byte_0_o, byte_1_o, byte_2_o, region_o);
          end
        end else begin
          oldest_pixel = expected_pixels.pop_front();
          if (byte_address_o !== oldest_pixel.addr || byte_0_o !== oldest_pixel.b0 ||
              byte_1_o !== oldest_pixel.b1 || byte_2_o !== oldest_pixel.b2 ||
              region_o !== oldest_pixel.region) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("pixel mismatch: expected addr %h bytes %h %h %h region %0d",
                       oldest_pixel.addr, oldest_pixel.b0, oldest_pixel.b1,
                       oldest_pixel.b2, oldest_pixel.region);
              $display("                got      addr %h bytes %h %h %h region %0d",
                       byte_address_o, byte_0_o, byte_1_o, byte_2_o, region_o);
            end
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= idle_pct());
    end
  end

  function automatic word_t draw_word(int x, int y, int ws, int we,
                                      logic [5:0] tcol, logic [1:0] tsel);
    word_t w;
    w.cmd         = CMD_DRAW;
    w.x           = 11'(x);
    w.y           = 11'(y);
    w.ws          = 12'(ws);
    w.we          = 12'(we);
    w.tcol        = tcol;
    w.tsel        = tsel;
    w.tidx        = 14'($urandom);
    w.tval        = 24'($urandom);
    w.drain_first = 1'b0;
    return w;
  endfunction

  task automatic queue_load(input logic [13:0] idx, input logic [23:0] val);
    word_t w;
    w = draw_word($urandom_range(0, MAX_ROW), $urandom_range(0, MAX_ROW),
                  $urandom_range(0, MAX_WALL_ROW), $urandom_range(0, MAX_WALL_ROW),
                  6'($urandom), 2'($urandom));
    w.cmd  = CMD_LOAD;
    w.tidx = idx;
    w.tval = val;
    loaded[idx] = 1'b1;
    pending_words.push_back(w);
  endtask

  // A wall row that would read a texel nobody has written yet gets a load
  // of that texel queued in front of it.
  task automatic queue_draw(input word_t w);
    wall_tap_t tap;
    if (on_screen(w) && row_region(w) == REGION_WALL) begin
      tap      = wall_tap(plan_acc, w);
      plan_acc = tap.acc;
      if (!loaded[tap.addr]) begin
        queue_load(tap.addr, 24'($urandom));
      end
    end
    pending_words.push_back(w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_TEXTURE_WIDTH:  raster_cfg.tex_w = data[6:0];
      CFG_TEXTURE_HEIGHT: raster_cfg.tex_h = data[6:0];
      CFG_SCREEN_WIDTH:   raster_cfg.scr_w = data[11:0];
      CFG_SCREEN_HEIGHT:  raster_cfg.scr_h = data[11:0];
      CFG_FILL_ABOVE:     raster_cfg.above = data;
      CFG_FILL_BELOW:     raster_cfg.below = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic directed_words();
    queue_load(14'd0, 24'hFFFFFF);
    queue_load(14'(STORE_DEPTH - 1), 24'h000000);
    queue_draw(draw_word(0, 0, 5, 10, 6'd0, 2'd0));
    queue_draw(draw_word(3, 2, 2, 6, 6'd63, 2'd3));
    queue_draw(draw_word(3, 3, 2, 6, 6'd63, 2'd3));
    queue_draw(draw_word(3, 5, 2, 6, 6'd63, 2'd3));
    queue_draw(draw_word(3, 6, 2, 6, 6'd63, 2'd3));
    queue_draw(draw_word(7, 2, 3, 3, 6'd10, 2'd1));
    queue_draw(draw_word(7, 3, 3, 3, 6'd10, 2'd1));
    queue_draw(draw_word(7, 4, 3, 3, 6'd10, 2'd1));
    queue_draw(draw_word(8, 3, 10, 4, 6'd5, 2'd2));
    queue_draw(draw_word(8, 12, 10, 4, 6'd5, 2'd2));
    queue_draw(draw_word(9, 5, 2, 30, 6'd17, 2'd1));
    queue_draw(draw_word(639, 479, 0, MAX_WALL_ROW, 6'd42, 2'd0));
    queue_draw(draw_word(640, 0, 0, 8, 6'd1, 2'd0));
    queue_draw(draw_word(0, 480, 0, 8, 6'd1, 2'd0));
    queue_draw(draw_word(MAX_ROW, MAX_ROW, MAX_WALL_ROW, MAX_WALL_ROW, 6'd63, 2'd3));
    queue_draw(draw_word(100, 200, MAX_WALL_ROW, 0, 6'd0, 2'd0));
    queue_draw(draw_word(5, 0, 0, 1, 6'd0, 2'd2));
    queue_draw(draw_word(5, 1, 0, 1, 6'd0, 2'd2));
  endtask

  task automatic configure_phase(input int phase);
    case (phase)
      1: begin
        write_reg(CFG_TEXTURE_WIDTH, 24'd64);
        write_reg(CFG_TEXTURE_HEIGHT, 24'd64);
        write_reg(CFG_SCREEN_WIDTH, 24'd2048);
        write_reg(CFG_SCREEN_HEIGHT, 24'd2048);
        write_reg(CFG_FILL_ABOVE, 24'hFFFFFF);
        write_reg(CFG_FILL_BELOW, 24'h000000);
      end
      2: begin
        write_reg(CFG_TEXTURE_WIDTH, 24'd1);
        write_reg(CFG_TEXTURE_HEIGHT, 24'd1);
        write_reg(CFG_SCREEN_WIDTH, 24'd1);
        write_reg(CFG_SCREEN_HEIGHT, 24'd1);
        write_reg(CFG_FILL_ABOVE, 24'h000000);
        write_reg(CFG_FILL_BELOW, 24'hFFFFFF);
      end
      3: begin
        write_reg(CFG_TEXTURE_WIDTH, 24'd0);
        write_reg(CFG_TEXTURE_HEIGHT, 24'd127);
        write_reg(CFG_SCREEN_WIDTH, 24'd320);
        write_reg(CFG_SCREEN_HEIGHT, 24'd240);
        write_reg(CFG_FILL_ABOVE, 24'($urandom));
        write_reg(CFG_FILL_BELOW, 24'($urandom));
        write_reg(CFG_UNUSED_IDX, 24'($urandom));
      end
      default: begin
        write_reg(CFG_TEXTURE_WIDTH, 24'($urandom_range(1, TEX_DIM)));
        write_reg(CFG_TEXTURE_HEIGHT, 24'($urandom_range(1, TEX_DIM)));
        write_reg(CFG_SCREEN_WIDTH, 24'($urandom_range(16, MAX_WALL_ROW)));
        write_reg(CFG_SCREEN_HEIGHT, 24'($urandom_range(16, MAX_WALL_ROW)));
        write_reg(CFG_FILL_ABOVE, 24'($urandom));
        write_reg(CFG_FILL_BELOW, 24'($urandom));
      end
    endcase
  endtask

  // Mostly runs down one column from at or above the wall start, with some
  // runs entering the wall past its first row, some with an inverted wall,
  // and a share of fully random words.
  task automatic random_columns(input int budget);
    int         start_size, rows, stride, len, x, y, y0, ws, we, tmp;
    logic [5:0] tcol;
    logic [1:0] tsel;
    word_t      w;
    start_size = pending_words.size();
    while (pending_words.size() < start_size + budget) begin
      if ($urandom_range(0, 99) < 12) begin
        if ($urandom_range(0, 1) == 0) begin
          queue_load(14'($urandom), 24'($urandom));
        end else begin
          queue_draw(draw_word($urandom_range(0, MAX_ROW), $urandom_range(0, MAX_ROW),
                               $urandom_range(0, MAX_WALL_ROW),
                               $urandom_range(0, MAX_WALL_ROW),
                               6'($urandom), 2'($urandom)));
        end
      end else begin
        x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_ROW)
                                        : $urandom_range(0, raster_cfg.scr_w - 1);
        ws = $urandom_range(0, raster_cfg.scr_h);
        case ($urandom_range(0, 7))
          0: len = 0;
          1: len = $urandom_range(1, MAX_WALL_ROW);
          default: len = $urandom_range(1, 48);
        endcase
        we  = (ws + len > MAX_WALL_ROW) ? MAX_WALL_ROW : ws + len;
        len = we - ws;
        y0  = (ws > 6) ? ws - $urandom_range(0, 6) : 0;
        if (len > 1 && $urandom_range(0, 9) == 0) begin
          y0 = ws + $urandom_range(1, len - 1);
        end
        if ($urandom_range(0, 9) == 0) begin
          tmp = ws;
          ws  = we;
          we  = tmp;
        end
        rows   = $urandom_range(3, 20);
        stride = 1 + ((len > 24) ? $urandom_range(0, len / 12) : 0);
        tcol   = 6'($urandom);
        tsel   = 2'($urandom);
        for (int k = 0; k < rows; k++) begin
          y = y0 + k * stride;
          if (y > MAX_ROW) begin
            break;
          end
          w = draw_word(x, y, ws, we, tcol, tsel);
          if (k == 0 && $urandom_range(0, 29) == 0) begin
            w.drain_first = 1'b1;
          end
          queue_draw(w);
        end
      end
    end
  endtask

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_words();
    wait_idle();
    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      configure_phase(phase);
      random_columns(phase == 2 ? 40 : 150);
      wait_idle();
    end
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/tcr_pkg.sv
sv/tcr_div.sv
sv/textured_column_renderer.sv
bench/tb_textured_column_renderer.sv
